>>> hdl/ncc_pkg.sv
// ----------------------------------------------------------------------------
// Normalized cross-correlation package
// Shared types and fixed constants for the multi-lag correlator.
// ----------------------------------------------------------------------------
package ncc_pkg;

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 24;
   localparam int FIELD_BITS    = 16;
   localparam int LAG_BITS      = 6;
   localparam int SHIFT_BITS    = 5;
   localparam int CORR_BITS     = 16;
   localparam int Q_BITS        = 16;
   localparam int Q_STEP_BITS   = 4;
   localparam logic [Q_BITS-1:0]    Q_ONE    = 16'h8000;
   localparam logic [CORR_BITS-1:0] CORR_MAX = 16'h7FFF;
   localparam int Q_FRAC_BITS   = 16;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SUM,
      ST_NQA,
      ST_SAQ,
      ST_NQB,
      ST_SBQ,
      ST_DADB,
      ST_LAG,
      ST_TADDR,
      ST_TDATA,
      ST_TCENTER,
      ST_TMUL,
      ST_NORM,
      ST_RR,
      ST_T,
      ST_TSQ,
      ST_TTRY,
      ST_EMIT
   } ncc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

>>> hdl/ncc_mul.sv
// ----------------------------------------------------------------------------
// Shared shift-add multiplier
// Unsigned product of two words, one bit of the second operand per cycle,
// finishing early once the remaining bits are zero.
// ----------------------------------------------------------------------------
module ncc_mul #(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WIDTH-1:0]      x,
   input  logic [WIDTH-1:0]      y,
   output ncc_pkg::mul_stat_type stat,
   output logic [WIDTH-1:0]      product
);
   import ncc_pkg::*;

   logic             busy_ff;
   logic [WIDTH-1:0] x_ff;
   logic [WIDTH-1:0] y_ff;
   logic [WIDTH-1:0] p_ff;

   always_comb begin
      stat.busy = busy_ff;
      stat.done = busy_ff && (y_ff == '0);
      product   = p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (stat.done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
         y_ff <= y;
         p_ff <= '0;
      end else if (busy_ff && (y_ff != '0)) begin
         if (y_ff[0]) begin
            p_ff <= p_ff + x_ff;
         end
         x_ff <= {x_ff[WIDTH-2:0], 1'b0};
         y_ff <= {1'b0, y_ff[WIDTH-1:1]};
      end
   end

endmodule

>>> hdl/normalized_cross_correlation_lags.sv
// ----------------------------------------------------------------------------
// Normalized cross-correlation over a window of lags
// Collects sample pairs into two stores, then emits one Q1.15 correlation of
// the z-scored series for every lag from minus to plus the configured span.
// ----------------------------------------------------------------------------
// Usage: pairs arrive on req_*, one item per cycle while loading; req_tlast
// closes a frame. The block then drops req_tready and computes 2*span+1
// results, sent on rsp_* in rising lag order, rsp_tlast on lag +span.
// The user writes the lag span on csr_* between frames; the block does not enforce this; csr_ready is always high.
// The stores hold MAX_SAMPLES pairs; later pairs of a frame are dropped and
// reported in rsp_tuser.
// Steps: a frame end runs the summation and then the variance products; per
// lag the block forms the centered product sum and the two sides of the ratio
// and then runs the ratio search. The variance, centered-term and ratio
// products all go through one shift-add multiplier that retires one operand
// bit per cycle.
// Reset empties the frame and clears the lag span; no clearing pass is needed.
// A stalled receiver holds the result register; computation of the next lag
// continues and waits only when its own result is ready.
// ----------------------------------------------------------------------------
module normalized_cross_correlation_lags #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_a [15:0], sample_b [31:16]
   input  logic [ncc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // lag [5:0], correlation [21:6], zero [23:22]
   output logic [ncc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // sample_overflow [0]
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ncc_pkg::SHIFT_BITS-1:0]     csr_wdata
);
   import ncc_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int CB = $clog2(MAX_SAMPLES + 1);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int FW = (SB > FIELD_BITS) ? SB : FIELD_BITS;
   localparam int SW = CB + SB;
   localparam int QW = 2 * SB + CB;
   localparam int DW = 2 * SB + 2 * CB;
   localparam int CW = CB + SB;
   localparam int NW = 2 * CW + CB + 1;
   localparam int LW = 4 * SB + 6 * CB + 32;
   localparam int HW = CB + SHIFT_BITS + 1;

   ncc_state_type state_ff, state_in;

   logic [SB-1:0] mem_a [MAX_SAMPLES];
   logic [SB-1:0] mem_b [MAX_SAMPLES];
   logic signed [SB-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_addr_a, rd_addr_b;

   logic [CB-1:0] count_ff;
   logic          overflow_ff;
   logic [SHIFT_BITS-1:0] lag_span_ff;
   logic          rsp_valid_ff;

   logic [CB-1:0] idx_ff;
   logic          v1_ff, v2_ff;
   logic signed [SW-1:0] sa_ff, sb_ff;
   logic signed [2*SB-1:0] sq_a_ff, sq_b_ff;
   logic [QW-1:0] qa_ff, qb_ff;
   logic [DW-1:0] da_ff, db_ff;
   logic [2*DW-1:0] dadb_ff;

   logic signed [LAG_BITS-1:0] k_ff;
   logic [SHIFT_BITS-1:0] sh_ff;
   logic [CB-1:0] ov_ff, j_ff;
   logic signed [CW:0] pa_ff, pb_ff, ca_ff, cb_ff;
   logic signed [NW-1:0] acc_ff;
   logic [2*CB-1:0] ov2_ff;
   logic [LW-1:0] rr_ff, t_ff;
   logic [Q_BITS-1:0] q_ff, cand_ff;
   logic [Q_STEP_BITS-1:0] step_ff;
   logic [2*Q_BITS+1:0] oo_ff;
   logic zero_ff;

   logic [LAG_BITS-1:0] rsp_lag_ff;
   logic [CORR_BITS-1:0] rsp_corr_ff;
   logic rsp_ovf_ff, rsp_last_ff;

   logic          req_fire, full, issue, out_load, mul_start, last_lag, term_last;
   logic          zero_lag;
   logic [FW-1:0] ext_a, ext_b;
   logic [SHIFT_BITS-1:0] sh_in;
   logic [SW-1:0] sa_mag, sb_mag;
   logic [CW-1:0] ca_mag, cb_mag;
   logic [NW-1:0] num_mag;
   logic [CB-1:0] ia, ib;
   logic [Q_BITS-1:0] cand_in;
   logic [Q_BITS:0] two_c;
   logic [CORR_BITS-1:0] corr_in;
   logic [LW-1:0] mul_x, mul_y, mul_p;
   mul_stat_type  mul_stat;

   ncc_mul #(.WIDTH(LW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .stat    (mul_stat),
      .product (mul_p)
   );

   assign req_fire  = req_tvalid && req_tready;
   assign full      = (count_ff == CB'(MAX_SAMPLES));
   assign issue     = (idx_ff != count_ff);
   assign ext_a     = FW'(req_tdata[FIELD_BITS-1:0]);
   assign ext_b     = FW'(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
   assign last_lag  = (k_ff == $signed({1'b0, lag_span_ff}));
   assign sh_in     = k_ff[LAG_BITS-1] ? SHIFT_BITS'(-k_ff) : SHIFT_BITS'(k_ff);
   assign zero_lag  = (HW'(sh_in) >= HW'(count_ff)) || (da_ff == '0) || (db_ff == '0);
   assign term_last = ((j_ff + 1'b1) == ov_ff);
   assign sa_mag    = sa_ff[SW-1] ? SW'(-sa_ff) : SW'(sa_ff);
   assign sb_mag    = sb_ff[SW-1] ? SW'(-sb_ff) : SW'(sb_ff);
   assign ca_mag    = ca_ff[CW] ? CW'(-ca_ff) : CW'(ca_ff);
   assign cb_mag    = cb_ff[CW] ? CW'(-cb_ff) : CW'(cb_ff);
   assign num_mag   = acc_ff[NW-1] ? NW'(-acc_ff) : NW'(acc_ff);
   assign ia        = k_ff[LAG_BITS-1] ? (j_ff + CB'(sh_ff)) : j_ff;
   assign ib        = k_ff[LAG_BITS-1] ? j_ff : (j_ff + CB'(sh_ff));
   assign rd_addr_a = (state_ff == ST_SUM) ? idx_ff[AW-1:0] : ia[AW-1:0];
   assign rd_addr_b = (state_ff == ST_SUM) ? idx_ff[AW-1:0] : ib[AW-1:0];
   assign cand_in   = q_ff | (Q_BITS'(1) << step_ff);
   assign two_c     = {cand_in, 1'b0} - 1'b1;

   always_comb begin
      if (zero_ff) begin
         corr_in = '0;
      end else if (acc_ff[NW-1]) begin
         corr_in = CORR_BITS'(-q_ff);
      end else if (q_ff > CORR_MAX) begin
         corr_in = CORR_MAX;
      end else begin
         corr_in = q_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:    if (req_fire && req_tlast) state_in = ST_SUM;
         ST_SUM:     if (!issue && !v1_ff && !v2_ff) state_in = ST_NQA;
         ST_NQA:     if (mul_stat.done) state_in = ST_SAQ;
         ST_SAQ:     if (mul_stat.done) state_in = ST_NQB;
         ST_NQB:     if (mul_stat.done) state_in = ST_SBQ;
         ST_SBQ:     if (mul_stat.done) state_in = ST_DADB;
         ST_DADB:    if (mul_stat.done) state_in = ST_LAG;
         ST_LAG:     state_in = zero_lag ? ST_EMIT : ST_TADDR;
         ST_TADDR:   state_in = ST_TDATA;
         ST_TDATA:   state_in = ST_TCENTER;
         ST_TCENTER: state_in = ST_TMUL;
         ST_TMUL:    if (mul_stat.done) state_in = term_last ? ST_NORM : ST_TADDR;
         ST_NORM:    state_in = (acc_ff == '0) ? ST_EMIT : ST_RR;
         ST_RR:      if (mul_stat.done) state_in = ST_T;
         ST_T:       if (mul_stat.done) state_in = ST_TSQ;
         ST_TSQ: begin
            if (cand_in[Q_BITS-1] && (cand_in[Q_BITS-2:0] != '0)) begin
               state_in = (step_ff == '0) ? ST_EMIT : ST_TSQ;
            end else begin
               state_in = ST_TTRY;
            end
         end
         ST_TTRY:    if (mul_stat.done) state_in = (step_ff == '0) ? ST_EMIT : ST_TSQ;
         ST_EMIT:    if (out_load) state_in = last_lag ? ST_LOAD : ST_LAG;
         default:    state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_LOAD);
      out_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
      mul_start  = 1'b0;
      mul_x      = '0;
      mul_y      = '0;
      unique case (state_ff)
         ST_NQA: begin
            mul_x = LW'(qa_ff);
            mul_y = LW'(count_ff);
            mul_start = !mul_stat.busy;
         end
         ST_SAQ: begin
            mul_x = LW'(sa_mag);
            mul_y = LW'(sa_mag);
            mul_start = !mul_stat.busy;
         end
         ST_NQB: begin
            mul_x = LW'(qb_ff);
            mul_y = LW'(count_ff);
            mul_start = !mul_stat.busy;
         end
         ST_SBQ: begin
            mul_x = LW'(sb_mag);
            mul_y = LW'(sb_mag);
            mul_start = !mul_stat.busy;
         end
         ST_DADB: begin
            mul_x = LW'(da_ff);
            mul_y = LW'(db_ff);
            mul_start = !mul_stat.busy;
         end
         ST_TMUL: begin
            mul_x = LW'(ca_mag);
            mul_y = LW'(cb_mag);
            mul_start = !mul_stat.busy;
         end
         ST_RR: begin
            mul_x = LW'(num_mag) << Q_FRAC_BITS;
            mul_y = LW'(num_mag) << Q_FRAC_BITS;
            mul_start = !mul_stat.busy;
         end
         ST_T: begin
            mul_x = LW'(dadb_ff);
            mul_y = LW'(ov2_ff);
            mul_start = !mul_stat.busy;
         end
         ST_TTRY: begin
            mul_x = t_ff;
            mul_y = LW'(oo_ff);
            mul_start = !mul_stat.busy;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && !full) begin
         mem_a[count_ff[AW-1:0]] <= ext_a[SB-1:0];
         mem_b[count_ff[AW-1:0]] <= ext_b[SB-1:0];
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         lag_span_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            lag_span_ff <= csr_wdata;
         end
         if (req_fire) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
            idx_ff <= '0;
         end else if ((state_ff == ST_SUM) && issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         v1_ff <= (state_ff == ST_SUM) && issue;
         v2_ff <= v1_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (last_lag) begin
               count_ff    <= '0;
               overflow_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         sa_ff <= '0;
         sb_ff <= '0;
         qa_ff <= '0;
         qb_ff <= '0;
         k_ff  <= -$signed({1'b0, lag_span_ff});
      end
      if (v1_ff) begin
         sa_ff   <= sa_ff + SW'(rd_a_ff);
         sb_ff   <= sb_ff + SW'(rd_b_ff);
         sq_a_ff <= rd_a_ff * rd_a_ff;
         sq_b_ff <= rd_b_ff * rd_b_ff;
      end
      if (v2_ff) begin
         qa_ff <= qa_ff + QW'($unsigned(sq_a_ff));
         qb_ff <= qb_ff + QW'($unsigned(sq_b_ff));
      end
      if (mul_stat.done) begin
         case (state_ff)
            ST_NQA:  da_ff   <= mul_p[DW-1:0];
            ST_SAQ:  da_ff   <= da_ff - mul_p[DW-1:0];
            ST_NQB:  db_ff   <= mul_p[DW-1:0];
            ST_SBQ:  db_ff   <= db_ff - mul_p[DW-1:0];
            ST_DADB: dadb_ff <= mul_p[2*DW-1:0];
            ST_TMUL: begin
               if (ca_ff[CW] ^ cb_ff[CW]) begin
                  acc_ff <= acc_ff - mul_p[NW-1:0];
               end else begin
                  acc_ff <= acc_ff + mul_p[NW-1:0];
               end
               j_ff <= j_ff + 1'b1;
            end
            ST_RR:   rr_ff <= mul_p;
            ST_T:    t_ff  <= mul_p;
            ST_TTRY: begin
               if (mul_p <= rr_ff) begin
                  q_ff <= cand_ff;
               end
               step_ff <= step_ff - 1'b1;
            end
            default: ;
         endcase
      end
      case (state_ff)
         ST_LAG: begin
            zero_ff <= zero_lag;
            sh_ff   <= sh_in;
            ov_ff   <= count_ff - CB'(sh_in);
            j_ff    <= '0;
            acc_ff  <= '0;
         end
         ST_TDATA: begin
            pa_ff <= $signed({1'b0, count_ff}) * rd_a_ff;
            pb_ff <= $signed({1'b0, count_ff}) * rd_b_ff;
         end
         ST_TCENTER: begin
            ca_ff <= pa_ff - (CW+1)'(sa_ff);
            cb_ff <= pb_ff - (CW+1)'(sb_ff);
         end
         ST_NORM: begin
            zero_ff <= (acc_ff == '0);
            ov2_ff  <= ov_ff * ov_ff;
            q_ff    <= '0;
            step_ff <= Q_STEP_BITS'(Q_BITS - 1);
         end
         ST_TSQ: begin
            cand_ff <= cand_in;
            oo_ff   <= two_c * two_c;
            if (cand_in[Q_BITS-1] && (cand_in[Q_BITS-2:0] != '0)) begin
               step_ff <= step_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_lag_ff  <= k_ff;
               rsp_corr_ff <= corr_in;
               rsp_ovf_ff  <= overflow_ff;
               rsp_last_ff <= last_lag;
               k_ff        <= k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_corr_ff, rsp_lag_ff});
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_ready_idle_mul: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mul_stat.busy)
      else $error("input accepted while the multiplier is busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(MAX_SAMPLES))
      else $error("pair count beyond store capacity");

   a_q_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && !zero_ff |-> q_ff <= Q_ONE)
      else $error("ratio search beyond unity");

endmodule

>>> bench/normalized_cross_correlation_lags_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the multi-lag normalized cross-correlator
// Streams frames of sample pairs with random gaps and stalls, predicts each lag
// result with exact wide-integer arithmetic or takes the correlation from a directed row, and checks each result item.
// ----------------------------------------------------------------------------
module normalized_cross_correlation_lags_tb;

   import ncc_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 20000000;

   typedef logic signed [255:0] wide_t;

   typedef struct {
      logic signed [5:0]  lag;
      logic signed [15:0] corr;
      logic               ovf;
      logic               last;
   } lag_result_t;

   typedef struct {
      int                 shift_cfg;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic               last;
      logic               known;
      logic signed [15:0] known_corr;
   } pair_row_t;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [SHIFT_BITS-1:0]    csr_wdata;

   int                 shift_now;
   int                 frame_len;
   logic               frame_dropped;
   int                 store_a [STORE_DEPTH];
   int                 store_b [STORE_DEPTH];
   lag_result_t        pending_lags[$];
   int                 errors;
   int                 cycles;
   logic               calm;
   int                 stall_left;

   normalized_cross_correlation_lags DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [15:0] ncc_ratio(wide_t num, longint ov, wide_t da,
                                                    wide_t db);
      logic  neg;
      wide_t mag;
      wide_t rr;
      wide_t t;
      int    lo;
      int    hi;
      int    mid;
      wide_t o;
      if (ov <= 0 || da == 0 || db == 0 || num == 0) return 16'sd0;
      neg = num < 0;
      mag = neg ? -num : num;
      rr = (mag * 65536) * (mag * 65536);
      t = da * db * wide_t'(ov) * wide_t'(ov);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         o = 2 * mid - 1;
         if (o * o * t <= rr) lo = mid;
         else hi = mid - 1;
      end
      if (neg) return 16'(-lo);
      return (lo > 32767) ? 16'sd32767 : 16'(lo);
   endfunction

   // Stores one accepted pair and, on the closing pair, queues every lag result.
   function automatic void take_pair(logic signed [15:0] a, logic signed [15:0] b,
                                     logic last, logic known,
                                     logic signed [15:0] known_corr);
      longint      n;
      longint      sa;
      longint      sb;
      longint      qa;
      longint      qb;
      wide_t       da;
      wide_t       db;
      wide_t       acc;
      longint      sh;
      longint      ov;
      longint      ca;
      longint      cb;
      lag_result_t res;
      if (frame_len < STORE_DEPTH) begin
         store_a[frame_len] = a;
         store_b[frame_len] = b;
         frame_len++;
      end else begin
         frame_dropped = 1'b1;
      end
      if (!last) return;
      n = frame_len;
      sa = 0; sb = 0; qa = 0; qb = 0;
      for (int i = 0; i < frame_len; i++) begin
         sa += store_a[i]; sb += store_b[i];
         qa += longint'(store_a[i]) * store_a[i];
         qb += longint'(store_b[i]) * store_b[i];
      end
      da = wide_t'(n) * wide_t'(qa) - wide_t'(sa) * wide_t'(sa);
      db = wide_t'(n) * wide_t'(qb) - wide_t'(sb) * wide_t'(sb);
      for (int k = -shift_now; k <= shift_now; k++) begin
         sh = (k < 0) ? -k : k;
         ov = n - sh;
         acc = 0;
         for (longint j = 0; j < ov; j++) begin
            ca = n * store_a[(k < 0) ? j + sh : j] - sa;
            cb = n * store_b[(k < 0) ? j : j + sh] - sb;
            acc += wide_t'(ca) * wide_t'(cb);
         end
         res.lag = 6'(k);
         res.corr = known ? known_corr : ncc_ratio(acc, ov, da, db);
         res.ovf = frame_dropped;
         res.last = (k == shift_now);
         pending_lags.push_back(res);
      end
      frame_len = 0;
      frame_dropped = 1'b0;
   endfunction

   task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
                            logic known = 1'b0, logic signed [15:0] known_corr = 0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {b, a};
      req_tlast = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      take_pair(a, b, last, known, known_corr);
      @(negedge clock);
   endtask

   task automatic write_shift(int value);
      req_tvalid = 1'b0;
      wait (pending_lags.size() == 0);
      repeat (40) @(negedge clock);
      csr_wdata = SHIFT_BITS'(value);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      shift_now = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2, 3, 4: return 16'($urandom_range(0, 20)) - 16'sd10;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(int len);
      logic               flat;
      logic signed [15:0] fixed_a;
      flat = ($urandom_range(0, 9) == 0);
      fixed_a = pick_sample();
      for (int i = 0; i < len; i++)
         send_pair(flat ? fixed_a : pick_sample(), pick_sample(), i == len - 1);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && !reset && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      lag_result_t want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_lags.size() == 0) begin
            $error("result item with no expectation: tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_lags.pop_front();
            if (rsp_tdata[5:0] !== want.lag) begin
               $error("lag: expected %0d, actual %0d", want.lag, $signed(rsp_tdata[5:0]));
               errors++;
            end
            if (rsp_tdata[21:6] !== want.corr) begin
               $error("correlation: expected %0d, actual %0d", want.corr,
                      $signed(rsp_tdata[21:6]));
               errors++;
            end
            if (rsp_tdata[23:22] !== 2'b00) begin
               $error("pad: expected 0, actual %0d", rsp_tdata[23:22]);
               errors++;
            end
            if (rsp_tuser[0] !== want.ovf) begin
               $error("sample_overflow: expected %0d, actual %0d", want.ovf, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_result: expected %0d, actual %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("normalized_cross_correlation_lags_tb NOT OK");
         $finish;
      end
   end

   pair_row_t directed[] = '{
      '{-1, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 16'sd0},
      '{-1, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 16'sd32767},
      '{-1, 16'sd5, -16'sd5, 1'b0, 1'b0, 16'sd0},
      '{-1, -16'sd5, 16'sd5, 1'b1, 1'b1, -16'sd32768},
      '{3, 16'sd7, 16'sd1, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd7, 16'sd2, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd7, 16'sd3, 1'b1, 1'b1, 16'sd0},
      '{-1, 16'sd100, -16'sd200, 1'b0, 1'b0, 16'sd0},
      '{-1, -16'sd300, 16'sd400, 1'b1, 1'b0, 16'sd0},
      '{-1, -16'sd32768, 16'sd32767, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{-1, -16'sd1, -16'sd1, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd1, 16'sd1, 1'b0, 1'b0, 16'sd0},
      '{-1, 16'sd12345, -16'sd12345, 1'b1, 1'b0, 16'sd0}
   };

   int phase_shifts[] = '{31, 0, 1, 5, 2, 17};

   initial begin
      int sent;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = '0;
      shift_now = 0;
      frame_len = 0;
      frame_dropped = 1'b0;
      errors = 0;
      cycles = 0;
      calm = 1'b0;
      stall_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].shift_cfg >= 0) write_shift(directed[i].shift_cfg);
         send_pair(directed[i].a, directed[i].b, directed[i].last, directed[i].known,
                   directed[i].known_corr);
      end

      foreach (phase_shifts[p]) begin
         write_shift(phase_shifts[p]);
         calm = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < ((phase_shifts[p] > 20) ? 16 : 40)) begin
            frame_len_pick: begin
               int len;
               len = (phase_shifts[p] > 20) ? $urandom_range(1, 8) : $urandom_range(1, 16);
               send_frame(len);
               sent += len;
            end
         end
      end

      calm = 1'b0;
      write_shift(0);
      send_frame(STORE_DEPTH + 2);
      write_shift(2);
      send_frame(5);

      req_tvalid = 1'b0;
      wait (pending_lags.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("normalized_cross_correlation_lags_tb OK");
      end else begin
         $display("normalized_cross_correlation_lags_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/ncc_pkg.sv
hdl/ncc_mul.sv
hdl/normalized_cross_correlation_lags.sv
bench/normalized_cross_correlation_lags_tb.sv
